// ----- design/timestamp_rollover_sequencer_unit_assert.svh -----
// Assertion macros for the timestamp rollover sequencer.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef TIMESTAMP_ROLLOVER_SEQUENCER_UNIT_ASSERT_SVH
`define TIMESTAMP_ROLLOVER_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define TRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRS_ASSERT_ALWAYS(label, cond, msg)
`define TRS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- design/trs_pkg.sv -----
// Shared types and constants of the timestamp rollover sequencer.
// No dependencies; used by trs_step and the top level.
package trs_pkg;

  localparam logic [63:0] DayUs   = 64'd86400000000;
  localparam logic [63:0] LateUs  = 64'd82800000000;
  localparam logic [63:0] EarlyUs = 64'd3600000000;
  localparam logic [63:0] Int64Min = {1'b1, 63'd0};

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_BACKWARD  = 3'd3,
    ST_RANGE_ERR = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] origin_time;
    logic        origin_set;
    logic [63:0] prev_abs;
    logic        prev_abs_set;
    logic [36:0] prev_clock;
    logic        prev_clock_set;
    logic [63:0] day_offset;
    logic [64:0] day_plus;       // day_offset + one day, kept ahead of use
    logic        error_latched;
  } trs_state_t;

  // all clear, except day_plus which starts one day ahead of a zero offset
  localparam trs_state_t StateReset = {64'd0, 1'b0, 64'd0, 1'b0, 37'd0, 1'b0,
                                       64'd0, 1'b0, DayUs, 1'b0};

  typedef struct packed {
    status_t     status;
    logic        rollover;
    logic [63:0] elapsed_us;
  } trs_result_t;

endpackage

// ----- design/trs_step.sv -----
// Per-row decision logic: result and next sequencer state for one row.
// Depends on trs_pkg.
module trs_step (
  input  logic               time_valid,
  input  logic               is_clock,
  input  logic [63:0]        time_us,
  input  trs_pkg::trs_state_t st,
  output trs_pkg::trs_state_t st_nxt,
  output trs_pkg::trs_result_t res
);
  import trs_pkg::*;

  logic        clk_bad;
  logic        roll;
  logic        plus_ovf;
  logic [63:0] off;
  logic [64:0] abs_sum;
  logic        abs_ok;
  logic [63:0] abs_val;
  logic [63:0] org;
  logic [64:0] el_sum;
  logic        el_ok;

  // clock rows must lie in [0, one day)
  assign clk_bad  = is_clock && (time_us[63] || (time_us >= DayUs));
  assign plus_ovf = (st.day_plus[64:63] != 2'b00);
  assign roll = is_clock && st.prev_clock_set && st.prev_abs_set
             && (time_us[36:0] < st.prev_clock)
             && ({27'd0, st.prev_clock} >= LateUs)
             && (time_us <= EarlyUs);
  assign off = roll ? st.day_plus[63:0] : st.day_offset;

  assign abs_sum = {time_us[63], time_us} + {off[63], off};
  assign abs_ok  = !is_clock ||
                   ((abs_sum[64] == abs_sum[63]) && (abs_sum[63:0] != Int64Min));
  assign abs_val = is_clock ? abs_sum[63:0] : time_us;

  assign org    = st.origin_set ? st.origin_time : abs_val;
  assign el_sum = {abs_val[63], abs_val} - {org[63], org};
  assign el_ok  = (el_sum[64] == el_sum[63]) && (el_sum[63:0] != Int64Min);

  always_comb begin
    st_nxt         = st;
    res.status     = ST_ACCEPTED;
    res.rollover   = 1'b0;
    res.elapsed_us = '0;
    if (st.error_latched) begin
      res.status = ST_RANGE_ERR;
    end else if (!time_valid || clk_bad) begin
      res.status = ST_INVALID;
    end else if ((time_us == Int64Min) || (roll && plus_ovf) || !abs_ok || !el_ok) begin
      res.status           = ST_RANGE_ERR;
      st_nxt.error_latched = 1'b1;
    end else begin
      st_nxt.origin_time = org;
      st_nxt.origin_set  = 1'b1;
      res.rollover       = roll;
      if (roll) begin
        st_nxt.day_offset = st.day_plus[63:0];
        st_nxt.day_plus   = st.day_plus + {1'b0, DayUs};
      end
      if (st.prev_abs_set && (abs_val == st.prev_abs)) begin
        res.status = ST_DUPLICATE;
      end else if (st.prev_abs_set && ($signed(abs_val) < $signed(st.prev_abs))) begin
        res.status = ST_BACKWARD;
      end else begin
        res.elapsed_us      = el_sum[63:0];
        st_nxt.prev_abs     = abs_val;
        st_nxt.prev_abs_set = 1'b1;
        if (is_clock) begin
          st_nxt.prev_clock     = time_us[36:0];
          st_nxt.prev_clock_set = 1'b1;
        end else begin
          st_nxt.prev_clock     = '0;
          st_nxt.prev_clock_set = 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/timestamp_rollover_sequencer_unit.sv -----
// Timestamp rollover sequencer: turns logged row timestamps into elapsed time
// since the first valid row, adding a day whenever a time-of-day row wraps past
// midnight. Each request returns exactly one result (status, rollover flag,
// elapsed microseconds). A request is registered on entry, then evaluated
// against the sequencer state and written to the result register when that
// register is free or draining, so a new request is taken every cycle unless
// out_stall holds it. The state update and result share one cycle, which sets
// that rate: the next row's decision reads state written by the previous row.
// Once a range error occurs every later request reports the error until reset.
// Depends on trs_pkg, trs_step and timestamp_rollover_sequencer_unit_assert.svh.
`include "timestamp_rollover_sequencer_unit_assert.svh"

module timestamp_rollover_sequencer_unit (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_time_valid,
  input  logic             in_is_clock,
  input  logic [63:0]      in_time_us,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output trs_pkg::status_t out_status,
  output logic             out_rollover,
  output logic [63:0]      out_elapsed_us
);
  import trs_pkg::*;

  // entry register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_time_valid_r;
  logic        s1_is_clock_r;
  logic [63:0] s1_time_us_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  trs_result_t out_r;

  // sequencer state
  trs_state_t  st_r, st_nxt;
  trs_result_t res;

  logic accept;
  logic advance;

  // the entry stage moves on when the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  trs_step u_step (
    .time_valid (s1_time_valid_r),
    .is_clock   (s1_is_clock_r),
    .time_us    (s1_time_us_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= StateReset;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time_valid_r <= in_time_valid;
      s1_is_clock_r   <= in_is_clock;
      s1_time_us_r    <= in_time_us;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_rollover   = out_r.rollover;
  assign out_elapsed_us = out_r.elapsed_us;

  // assertions
  `TRS_ASSERT_NEXT(a_error_sticky, st_r.error_latched, st_r.error_latched, "error not sticky")
  `TRS_ASSERT_ALWAYS(a_elapsed_zero, !out_valid_r || (out_r.status == ST_ACCEPTED) || (out_r.elapsed_us == 64'd0), "elapsed set on skipped row")
  `TRS_ASSERT_ALWAYS(a_roll_status, !out_valid_r || !out_r.rollover || ((out_r.status != ST_INVALID) && (out_r.status != ST_RANGE_ERR)), "rollover on invalid or error row")
  `TRS_ASSERT_ALWAYS(a_no_stall_empty, s1_valid_r || !in_stall, "stall with empty entry stage")

endmodule

// ----- verif/timestamp_rollover_sequencer_unit_checker.sv -----
// Scoreboard for the timestamp rollover sequencer: watches both channels,
// predicts each result from the accepted requests and compares field by field.
// Depends on trs_pkg for the status codes and the result layout.
module timestamp_rollover_sequencer_unit_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_time_valid,
  input  logic             in_is_clock,
  input  logic [63:0]      in_time_us,
  input  logic             out_valid,
  input  logic             out_stall,
  input  trs_pkg::status_t out_status,
  input  logic             out_rollover,
  input  logic [63:0]      out_elapsed_us,
  output int               mismatches,
  output int               outstanding
);
  import trs_pkg::*;

  localparam longint MAX_L   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint DAY_L   = longint'(DayUs);
  localparam longint LATE_L  = longint'(LateUs);
  localparam longint EARLY_L = longint'(EarlyUs);

  // predicted sequencer state
  longint      org_time;
  bit          org_known;
  longint      last_abs;
  bit          last_abs_known;
  logic [36:0] last_tod;
  bit          last_tod_known;
  longint      day_shift;
  bit          stuck_err;

  trs_result_t rows_due[$];
  int          err_total = 0;

  // sum must stay inside [-(2^63-1), 2^63-1], so it never reaches -2^63
  function automatic bit add_open(input longint a, input longint b, output longint s);
    s = 0;
    if (b > 0 && a > MAX_L - b) return 1'b0;
    if (b < 0 && a < -MAX_L - b) return 1'b0;
    s = a + b;
    return 1'b1;
  endfunction

  function automatic trs_result_t compute_row(input logic tv, input logic ck,
                                              input logic [63:0] raw);
    trs_result_t r;
    longint      t;
    longint      absol;
    longint      elapsed;
    longint      shift;
    longint      org;
    longint      tod_prev;
    bit          rolled;
    r.status     = ST_RANGE_ERR;
    r.rollover   = 1'b0;
    r.elapsed_us = '0;
    t       = raw;
    absol   = t;
    shift   = day_shift;
    elapsed = 0;
    rolled  = 1'b0;
    if (stuck_err) return r;
    if (!tv || (ck && (t < 0 || t >= DAY_L))) begin
      r.status = ST_INVALID;
      return r;
    end
    if (raw == Int64Min) begin
      stuck_err = 1'b1;
      return r;
    end
    if (ck) begin
      tod_prev = longint'({27'd0, last_tod});
      if (last_tod_known && last_abs_known && t < tod_prev &&
          tod_prev >= LATE_L && t <= EARLY_L) begin
        if (!add_open(day_shift, DAY_L, shift)) begin
          stuck_err = 1'b1;
          return r;
        end
        rolled = 1'b1;
      end
      if (!add_open(t, shift, absol)) begin
        stuck_err = 1'b1;
        return r;
      end
    end
    org = org_known ? org_time : absol;
    if (!add_open(absol, -org, elapsed)) begin
      stuck_err = 1'b1;
      return r;
    end
    // origin and day count stick even when the row is skipped below
    org_time   = org;
    org_known  = 1'b1;
    day_shift  = shift;
    r.rollover = rolled;
    if (last_abs_known && absol == last_abs) begin
      r.status = ST_DUPLICATE;
      return r;
    end
    if (last_abs_known && absol < last_abs) begin
      r.status = ST_BACKWARD;
      return r;
    end
    last_abs       = absol;
    last_abs_known = 1'b1;
    last_tod_known = ck;
    last_tod       = ck ? raw[36:0] : '0;
    r.status       = ST_ACCEPTED;
    r.elapsed_us   = elapsed;
    return r;
  endfunction

  always @(posedge clk) begin
    trs_result_t want;
    if (!rst_n) begin
      org_time       = 0;
      org_known      = 1'b0;
      last_abs       = 0;
      last_abs_known = 1'b0;
      last_tod       = '0;
      last_tod_known = 1'b0;
      day_shift      = 0;
      stuck_err      = 1'b0;
      rows_due.delete();
    end else begin
      // queue first so a same-edge result still finds its request
      if (in_valid && !in_stall)
        rows_due.push_back(compute_row(in_time_valid, in_is_clock, in_time_us));
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          $error("result with no request pending: status %0d", out_status);
          err_total++;
        end else begin
          want = rows_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_total++;
          end
          if (out_rollover !== want.rollover) begin
            $error("rollover: expected %0d, got %0d", want.rollover, out_rollover);
            err_total++;
          end
          if (out_elapsed_us !== want.elapsed_us) begin
            $error("elapsed_us: expected %0d, got %0d",
                   $signed(want.elapsed_us), $signed(out_elapsed_us));
            err_total++;
          end
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= rows_due.size();
  end

endmodule

// ----- verif/tb_timestamp_rollover_sequencer_unit.sv -----
// Testbench top for timestamp_rollover_sequencer_unit: clock, reset, request
// stimulus, result-side stalls and the verdict. Checking lives in
// timestamp_rollover_sequencer_unit_checker; types come from trs_pkg.
module tb_timestamp_rollover_sequencer_unit;
  import trs_pkg::*;

  localparam longint MAX_L   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN_L   = longint'(Int64Min);
  localparam longint HOUR_L  = 64'sd3600000000;
  localparam longint DAY_L   = longint'(DayUs);
  localparam longint LATE_L  = longint'(LateUs);
  localparam longint EARLY_L = longint'(EarlyUs);

  localparam int RANDOM_ROWS  = 1760;
  localparam int CALM_ROWS    = 200;    // tail of the random part with no idling
  localparam int DRAIN_CYCLES = 8;      // extra margin after the last result
  // ~1800 requests, each with its worst-case idle burst, stall burst and pipeline
  // delay, taken several times over
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_time_valid = 1'b0;
  logic        in_is_clock   = 1'b0;
  logic [63:0] in_time_us    = '0;
  logic        out_stall     = 1'b0;
  logic        in_stall;
  logic        out_valid;
  status_t     out_status;
  logic        out_rollover;
  logic [63:0] out_elapsed_us;

  int mismatches;
  int outstanding;
  int cycles     = 0;
  int stall_left = 0;
  bit bursty     = 1'b1;

  // request generator bookkeeping: mirrors the accepted timeline so that
  // well-formed rows keep getting past the duplicate/backward filters
  longint gen_offset;      // day offset the block should hold
  longint gen_tod;         // time of day of the last accepted row
  bit     gen_tod_clock;   // last accepted row was a clock row
  logic   last_clock;      // last well-formed row, replayed as a duplicate
  longint last_t;

  timestamp_rollover_sequencer_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_time_valid (in_time_valid),
    .in_is_clock   (in_is_clock),
    .in_time_us    (in_time_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_rollover  (out_rollover),
    .out_elapsed_us(out_elapsed_us)
  );

  timestamp_rollover_sequencer_unit_checker row_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_time_valid (in_time_valid),
    .in_is_clock   (in_is_clock),
    .in_time_us    (in_time_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_rollover  (out_rollover),
    .out_elapsed_us(out_elapsed_us),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timestamp_rollover_sequencer_unit: mismatch");
      $finish;
    end
  end

  // result-side back-pressure: random bursts of stalled cycles
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (bursty && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // uniform in [0, n), n > 0
  function automatic longint rand_below(input longint n);
    longint r;
    r = longint'({$urandom & 32'h7FFF_FFFF, $urandom});
    return r % n;
  endfunction

  // one request; an optional idle burst first, then hold until accepted
  task automatic push_row(input logic tv, input logic ck, input longint t);
    if (bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_time_valid <= tv;
    in_is_clock   <= ck;
    in_time_us    <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // remember a well-formed row for later duplicates
  task automatic push_good(input logic ck, input longint t);
    last_clock = ck;
    last_t     = t;
    push_row(1'b1, ck, t);
  endtask

  initial begin
    longint nxt;
    longint step;
    longint t;
    int     sel;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    push_row(1'b0, 1'b0, MIN_L);            // invalid before any origin
    push_row(1'b1, 1'b1, -1);               // clock below range
    push_row(1'b1, 1'b1, DAY_L);            // clock at one day: out of range
    push_row(1'b1, 1'b1, 5 * HOUR_L);       // first valid row sets the origin
    push_row(1'b1, 1'b1, 5 * HOUR_L);       // duplicate
    push_row(1'b1, 1'b1, 4 * HOUR_L);       // backward
    push_row(1'b1, 1'b0, -1);               // relative, backward
    push_row(1'b1, 1'b1, LATE_L);           // exactly 23 h
    push_row(1'b1, 1'b1, DAY_L - 1);        // last microsecond of the day
    push_row(1'b1, 1'b1, 0);                // midnight rollover to 0
    push_row(1'b1, 1'b1, 0);                // same time again, no rollover
    push_row(1'b1, 1'b1, EARLY_L);          // exactly 1 h, no rollover from 0
    push_row(1'b1, 1'b1, LATE_L);
    push_row(1'b1, 1'b1, EARLY_L);          // rollover at both thresholds
    push_row(1'b0, 1'b1, MAX_L);            // invalid flag wins
    push_row(1'b1, 1'b1, MAX_L);            // clock far out of range
    push_row(1'b1, 1'b1, -MAX_L);
    push_row(1'b1, 1'b1, MIN_L);            // clock check precedes -2^63 check
    push_row(1'b1, 1'b1, LATE_L);
    push_row(1'b1, 1'b0, 2 * DAY_L + LATE_L + 1);  // relative clears clock history
    push_row(1'b1, 1'b0, 2 * DAY_L + LATE_L + 1);  // relative duplicate
    push_row(1'b1, 1'b1, LATE_L + HOUR_L / 2);
    push_row(1'b1, 1'b1, EARLY_L + 1);      // just past 1 h: backward, no rollover

    gen_offset    = 2 * DAY_L;
    gen_tod       = LATE_L + HOUR_L / 2;
    gen_tod_clock = 1'b1;
    last_clock    = 1'b1;
    last_t        = gen_tod;

    // ---- random part: mostly a walking day log, the rest noise ----
    for (int i = 0; i < RANDOM_ROWS; i++) begin
      // a quiet stretch in the middle, and none at the end
      bursty <= (i < 1000 || i >= 1250) && (i < RANDOM_ROWS - CALM_ROWS);

      // sender holds off once until the pipeline has fully drained
      if (i == RANDOM_ROWS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end

      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        if ($urandom_range(0, 6) == 0 && gen_tod < LATE_L - 1) begin
          // relative row inside today's window, so clock rows can follow
          gen_tod       = gen_tod + 1 + rand_below(LATE_L - 1 - gen_tod);
          gen_tod_clock = 1'b0;
          push_good(1'b0, gen_offset + gen_tod);
        end else begin
          case ($urandom_range(0, 3))
            0:       step = rand_below(10);
            1:       step = rand_below(1000000);
            default: step = rand_below(4 * HOUR_L);
          endcase
          nxt = gen_tod + 1 + step;
          if (nxt >= DAY_L) begin
            if (gen_tod_clock && gen_tod >= LATE_L) begin
              // late evening to early morning: the block must see a rollover
              nxt        = rand_below(EARLY_L + 1);
              gen_offset = gen_offset + DAY_L;
            end else begin
              nxt = LATE_L + rand_below(DAY_L - LATE_L);
            end
          end
          gen_tod       = nxt;
          gen_tod_clock = 1'b1;
          push_good(1'b1, nxt);
        end
      end else begin
        case ($urandom_range(0, 5))
          0: push_row(1'b0, 1'($urandom_range(0, 1)), longint'({$urandom, $urandom}));
          1: begin
            if ($urandom_range(0, 1) == 1) t = -(1 + rand_below(MAX_L));
            else                           t = DAY_L + rand_below(MAX_L - DAY_L + 1);
            push_row(1'b1, 1'b1, t);
          end
          2: push_row(1'b1, last_clock, last_t);
          3: begin
            // earlier clock time that must not look like a rollover
            if (gen_tod >= LATE_L) begin
              push_row(1'b1, 1'b1, EARLY_L + 1 + rand_below(gen_tod - EARLY_L - 1));
            end else if (gen_tod > 0) begin
              push_row(1'b1, 1'b1, rand_below(gen_tod));
            end else begin
              push_row(1'b1, last_clock, last_t);
            end
          end
          4: begin
            if ($urandom_range(0, 1) == 1) step = rand_below(1000);
            else                           step = rand_below(64'sh4000_0000_0000_0000);
            push_row(1'b1, 1'b0, gen_offset + gen_tod - 1 - step);
          end
          default: push_row(1'b0, 1'b1, rand_below(DAY_L));
        endcase
      end
    end

    // ---- closing part: range extremes, then the sticky error ----
    push_row(1'b1, 1'b0, MAX_L);            // accepted, largest elapsed time
    push_row(1'b1, 1'b0, MAX_L);            // duplicate at the top
    push_row(1'b1, 1'b0, 0);                // backward
    if ($urandom_range(0, 1) == 1) push_row(1'b1, 1'b0, MIN_L);   // -2^63 itself
    else                           push_row(1'b1, 1'b0, -MAX_L);  // elapsed overflow
    for (int i = 0; i < 12; i++)
      push_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               longint'({$urandom, $urandom}));
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("timestamp_rollover_sequencer_unit: match");
    else
      $display("timestamp_rollover_sequencer_unit: mismatch");
    $finish;
  end

endmodule
